>>> hw/rtl/cebu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebu_pkg
// Shared types, constants and arithmetic helpers of the camera basis block.
// ----------------------------------------------------------------------------
package cebu_pkg;

    typedef logic signed [32:0] wide_t;
    typedef logic signed [15:0] comp_t;
    typedef logic signed [31:0] pos_t;
    typedef logic signed [25:0] ang_t;
    typedef logic signed [65:0] prod_t;

    typedef struct packed {
        logic  done;
        wide_t cos_v;
        wide_t sin_v;
    } cordic_res_t;

    localparam int    CORDIC_STEPS = 16;
    localparam wide_t CORDIC_X0    = 33'sd652032874;
    localparam ang_t  DEG_90       = 26'sd5898240;
    localparam ang_t  DEG_180      = 26'sd11796480;
    localparam ang_t  DEG_360      = 26'sd23592960;

    // Arctangent of 2^-i in degrees scaled by 2^16.
    function automatic ang_t atan_deg(input logic [3:0] i);
        ang_t a;
        unique case (i)
            4'd0:  a = 26'sd2949120;
            4'd1:  a = 26'sd1740967;
            4'd2:  a = 26'sd919879;
            4'd3:  a = 26'sd466945;
            4'd4:  a = 26'sd234379;
            4'd5:  a = 26'sd117304;
            4'd6:  a = 26'sd58666;
            4'd7:  a = 26'sd29335;
            4'd8:  a = 26'sd14668;
            4'd9:  a = 26'sd7334;
            4'd10: a = 26'sd3667;
            4'd11: a = 26'sd1833;
            4'd12: a = 26'sd917;
            4'd13: a = 26'sd458;
            4'd14: a = 26'sd229;
            4'd15: a = 26'sd115;
        endcase
        return a;
    endfunction

    function automatic wide_t sx16(input comp_t v);
        return {{17{v[15]}}, v};
    endfunction

    // Add half an LSB, then shift right arithmetically.
    function automatic wide_t rnd_sh(input prod_t p, input int s);
        prod_t t;
        t = (p + (66'sd1 <<< (s - 1))) >>> s;
        return t[32:0];
    endfunction

    function automatic pos_t add_sat(input pos_t p, input wide_t d);
        logic signed [33:0] s;
        s = {{2{p[31]}}, p} + {d[32], d};
        if (s > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        return s[31:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/euler_camera_basis_update_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_camera_basis_update_top
// First-person camera basis: front, right and up from yaw and pitch, and a
// position that moves along front by a configured step.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per item. s_tuser selects a load (1) or
// an update (0). Output stream m_*: one transaction per item carrying the
// stored basis and position after that item. cfg_* writes the Q8.8 step
// speed; the user writes it only while the block is idle, which the block
// itself does not enforce. cfg_* is always ready. A load reaches the output
// register in the cycle after it is accepted. An update makes two CORDIC
// runs, the front products, then three normalizations (the squares, the
// 32-step square root and three divisions), the up cross product and the
// position, with the shared multiplier stepping through products between
// them. A degenerate orientation (pitch at plus or minus 90 degrees) skips
// two normalizations and the cross product.
// s_tready is high only while no item is in progress. A result waits in the
// output register until m_tready; no new item is taken meanwhile.
// Reset clears position, basis and step speed to zero.
// ----------------------------------------------------------------------------
module euler_camera_basis_update_top
    import cebu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // yaw_deg[15:0], pitch_deg[31:16], load_x[63:32], load_y[95:64],
    // load_z[127:96]
    input  wire logic [127:0] s_tdata,
    // command[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // front_x/y/z[47:0], right_x/y/z[95:48], up_x/y/z[143:96],
    // pos_x[175:144], pos_y[207:176], pos_z[239:208]
    output logic [239:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_YAW   = 4'd1;
    localparam logic [3:0] ST_PITCH = 4'd2;
    localparam logic [3:0] ST_FMUL  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_NORM  = 4'd5;
    localparam logic [3:0] ST_UMUL  = 4'd6;
    localparam logic [3:0] ST_POS   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [1:0] PH_FRONT = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_UP    = 2'd2;

    logic [3:0]  state_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  phase_reg;
    logic        norm_start_reg;
    comp_t       speed_reg;
    logic [15:0] pitch_reg;
    wide_t       cy_reg, sy_reg, cp_reg, sp_reg;
    wide_t [2:0] vec_reg;
    logic [63:0] sum_reg;
    prod_t       acc_reg;
    prod_t       prod_reg;
    comp_t [2:0] f_reg, r_reg, u_reg;
    pos_t  [2:0] pos_reg;

    logic        accept;
    logic        cord_start;
    logic [15:0] cord_angle;
    cordic_res_t cres;
    logic        norm_done;
    comp_t [2:0] norm_res;
    wide_t       mul_a, mul_b;
    prod_t       product;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign cfg_ready  = 1'b1;
    assign m_tdata    = {pos_reg, u_reg, r_reg, f_reg};
    assign cord_start = (accept && !s_tuser[0]) || (state_reg == ST_YAW && cres.done);
    assign cord_angle = (state_reg == ST_IDLE) ? s_tdata[15:0] : pitch_reg;

    cebu_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .angle (cord_angle),
        .res   (cres)
    );

    cebu_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start_reg),
        .sum   (sum_reg),
        .vec   (vec_reg),
        .done  (norm_done),
        .res   (norm_res)
    );

    // Operand selection for the shared multiplier; its product is registered
    // in prod_reg before it is consumed.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FMUL:
            begin
                mul_a = (cnt_reg == 3'd0) ? cy_reg : sy_reg;
                mul_b = cp_reg;
            end
            ST_SQ:
            begin
                unique case (cnt_reg)
                    3'd0:    mul_a = vec_reg[0];
                    3'd1:    mul_a = vec_reg[1];
                    default: mul_a = vec_reg[2];
                endcase
                mul_b = mul_a;
            end
            ST_UMUL:
            begin
                unique case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = sx16(f_reg[1]);
                        mul_b = sx16(r_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = sx16(f_reg[2]);
                        mul_b = sx16(r_reg[0]);
                    end
                    3'd2:
                    begin
                        mul_a = sx16(f_reg[0]);
                        mul_b = sx16(r_reg[2]);
                    end
                    default:
                    begin
                        mul_a = sx16(f_reg[1]);
                        mul_b = sx16(r_reg[0]);
                    end
                endcase
            end
            ST_POS:
            begin
                unique case (cnt_reg)
                    3'd0:    mul_a = sx16(f_reg[0]);
                    3'd1:    mul_a = sx16(f_reg[1]);
                    default: mul_a = sx16(f_reg[2]);
                endcase
                mul_b = sx16(speed_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= PH_FRONT;
            norm_start_reg <= 1'b0;
            speed_reg      <= '0;
            f_reg          <= '0;
            r_reg          <= '0;
            u_reg          <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            prod_reg       <= product;
            norm_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                speed_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser[0])
                        begin
                            pos_reg[0] <= s_tdata[63:32];
                            pos_reg[1] <= s_tdata[95:64];
                            pos_reg[2] <= s_tdata[127:96];
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            pitch_reg <= s_tdata[31:16];
                            state_reg <= ST_YAW;
                        end
                    end
                end
                ST_YAW:
                begin
                    if (cres.done)
                    begin
                        cy_reg    <= cres.cos_v;
                        sy_reg    <= cres.sin_v;
                        state_reg <= ST_PITCH;
                    end
                end
                ST_PITCH:
                begin
                    if (cres.done)
                    begin
                        cp_reg    <= cres.cos_v;
                        sp_reg    <= cres.sin_v;
                        cnt_reg   <= '0;
                        state_reg <= ST_FMUL;
                    end
                end
                ST_FMUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd1)
                        vec_reg[0] <= rnd_sh(prod_reg, 30);
                    if (cnt_reg == 3'd2)
                    begin
                        vec_reg[2] <= rnd_sh(prod_reg, 30);
                        vec_reg[1] <= sp_reg;
                        sum_reg    <= '0;
                        cnt_reg    <= '0;
                        phase_reg  <= PH_FRONT;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0)
                        sum_reg <= sum_reg + prod_reg[63:0];
                    if (cnt_reg == 3'd3)
                    begin
                        norm_start_reg <= 1'b1;
                        state_reg      <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (norm_done)
                    begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        unique case (phase_reg)
                            PH_FRONT:
                            begin
                                f_reg <= norm_res;
                                if (norm_res[0] == 16'sd0 && norm_res[2] == 16'sd0)
                                begin
                                    // Looking straight up or down: no right vector.
                                    r_reg     <= '0;
                                    u_reg     <= '0;
                                    state_reg <= ST_POS;
                                end
                                else
                                begin
                                    vec_reg[0] <= sx16(norm_res[2]);
                                    vec_reg[1] <= '0;
                                    vec_reg[2] <= -sx16(norm_res[0]);
                                    phase_reg  <= PH_RIGHT;
                                    state_reg  <= ST_SQ;
                                end
                            end
                            PH_RIGHT:
                            begin
                                r_reg     <= norm_res;
                                state_reg <= ST_UMUL;
                            end
                            default:
                            begin
                                u_reg     <= norm_res;
                                state_reg <= ST_POS;
                            end
                        endcase
                    end
                end
                ST_UMUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    unique case (cnt_reg)
                        3'd1:    vec_reg[0] <= rnd_sh(prod_reg, 14);
                        3'd2:    acc_reg <= prod_reg;
                        3'd3:    vec_reg[1] <= rnd_sh(acc_reg - prod_reg, 14);
                        3'd4:
                        begin
                            vec_reg[2] <= rnd_sh(-prod_reg, 14);
                            cnt_reg    <= '0;
                            phase_reg  <= PH_UP;
                            state_reg  <= ST_SQ;
                        end
                        default: acc_reg <= acc_reg;
                    endcase
                end
                ST_POS:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    unique case (cnt_reg)
                        3'd1: pos_reg[0] <= add_sat(pos_reg[0], rnd_sh(prod_reg, 6));
                        3'd2: pos_reg[1] <= add_sat(pos_reg[1], rnd_sh(prod_reg, 6));
                        3'd3:
                        begin
                            pos_reg[2] <= add_sat(pos_reg[2], rnd_sh(prod_reg, 6));
                            state_reg  <= ST_OUT;
                        end
                        default: pos_reg <= pos_reg;
                    endcase
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("block ready right after taking an item");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[0]) |=> (m_tvalid && pos_reg[0] == $past(s_tdata[63:32])))
        else $error("load transaction did not produce its result");

endmodule
`default_nettype wire

>>> hw/rtl/cebu_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebu_cordic
// Iterative rotation CORDIC: Q9.7 degrees in, cosine and sine in Q2.30 out.
// ----------------------------------------------------------------------------
module cebu_cordic
    import cebu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] angle,
    output cordic_res_t      res
);

    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [3:0]  it_reg;
    wide_t       x_reg;
    wide_t       y_reg;
    ang_t        z_reg;

    ang_t za, zb, zc, zd;
    logic neg0;
    wide_t dx, dy;

    always_comb
    begin
        za = {angle[15], angle, 9'b0};
        zb = (za >= DEG_180) ? za - DEG_360 : za;
        zc = (zb < -DEG_180) ? zb + DEG_360 : zb;
        neg0 = 1'b0;
        zd = zc;
        if (zc > DEG_90)
        begin
            zd = zc - DEG_180;
            neg0 = 1'b1;
        end
        else if (zc < -DEG_90)
        begin
            zd = zc + DEG_180;
            neg0 = 1'b1;
        end
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
                x_reg    <= CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= zd;
                neg_reg  <= neg0;
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_deg(it_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_deg(it_reg);
                end
                it_reg <= it_reg + 4'd1;
                if (it_reg == 4'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done  = done_reg;
    assign res.cos_v = neg_reg ? -x_reg : x_reg;
    assign res.sin_v = neg_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

>>> hw/rtl/cebu_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebu_norm
// Vector normalizer: bit-pair integer square root, then a restoring divider
// that scales each component to Q2.14, rounded half away from zero.
// ----------------------------------------------------------------------------
module cebu_norm
    import cebu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] sum,
    input  wire wide_t [2:0] vec,
    output logic             done,
    output comp_t [2:0]      res
);

    localparam logic [1:0] NS_IDLE = 2'd0;
    localparam logic [1:0] NS_SQRT = 2'd1;
    localparam logic [1:0] NS_LOAD = 2'd2;
    localparam logic [1:0] NS_DIV  = 2'd3;

    logic [1:0]  state_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  idx_reg;
    logic [63:0] n_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [48:0] rem_reg;
    logic [48:0] d_reg;
    logic [15:0] q_reg;
    wide_t [2:0] vec_reg;
    comp_t [2:0] res_reg;

    logic [63:0] trial;
    wide_t       sel;
    wide_t       mag;
    logic        take;
    logic [15:0] qn;
    logic signed [16:0] qs;
    comp_t       qout;

    always_comb
    begin
        trial = root_reg + bit_reg;
        unique case (idx_reg)
            2'd0:    sel = vec_reg[0];
            2'd1:    sel = vec_reg[1];
            default: sel = vec_reg[2];
        endcase
        mag  = (sel < 0) ? -sel : sel;
        take = (rem_reg >= d_reg);
        qn   = {q_reg[14:0], take};
        qs   = (sel < 0) ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        if (qs > 17'sd32767)
            qout = 16'sh7FFF;
        else if (qs < -17'sd32768)
            qout = 16'sh8000;
        else
            qout = qs[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NS_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                NS_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= sum;
                        root_reg  <= '0;
                        bit_reg   <= 64'h4000_0000_0000_0000;
                        cnt_reg   <= '0;
                        vec_reg   <= vec;
                        state_reg <= NS_SQRT;
                    end
                end
                NS_SQRT:
                begin
                    if (n_reg >= trial)
                    begin
                        n_reg    <= n_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        idx_reg   <= '0;
                        state_reg <= NS_LOAD;
                    end
                end
                NS_LOAD:
                begin
                    if (root_reg == 64'd0)
                    begin
                        // A zero-length vector normalizes to all zero.
                        res_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= NS_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= ({17'b0, mag[31:0]} << 14) + 49'(root_reg >> 1);
                        d_reg     <= {1'b0, root_reg[32:0], 15'b0};
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= NS_DIV;
                    end
                end
                NS_DIV:
                begin
                    if (take)
                        rem_reg <= rem_reg - d_reg;
                    q_reg   <= qn;
                    d_reg   <= d_reg >> 1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        unique case (idx_reg)
                            2'd0:    res_reg[0] <= qout;
                            2'd1:    res_reg[1] <= qout;
                            default: res_reg[2] <= qout;
                        endcase
                        if (idx_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= NS_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= NS_LOAD;
                        end
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Camera basis block testbench
// Drives load and update items with random idling on both streams, predicts
// the basis and position of every item and compares each result field by
// field. The step speed is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import cebu_pkg::*;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] lz;
    } cam_item_t;

    typedef logic [239:0] cam_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    cam_item_t   pending_items[$];
    cam_result_t expected_results[$];
    int          error_count = 0;
    bit          stimulus_done = 1'b0;
    bit          quiet_mode = 1'b0;
    bit          hold_sender = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    // Predictor state.
    longint      pred_pos[3];
    longint      pred_basis[9];
    longint      pred_speed;

    euler_camera_basis_update_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[16];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tab[i];
    endfunction

    task automatic angle_sincos(input logic signed [15:0] q97, output longint c,
                                output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(q97) * 512;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z >= 180 * 65536)
            z -= 360 * 65536;
        if (z < -180 * 65536)
            z += 360 * 65536;
        if (z > 90 * 65536)
        begin
            z -= 180 * 65536;
            flip = 1'b1;
        end
        else if (z < -90 * 65536)
        begin
            z += 180 * 65536;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic normalize_vec(input longint v[3], output longint o[3]);
        longint mag[3];
        longint sum;
        longint len;
        longint q;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                o[i] = 0;
            else
            begin
                q = (mag[i] * 16384 + len / 2) / len;
                if (v[i] < 0)
                    q = -q;
                o[i] = clamp(q, -32768, 32767);
            end
        end
    endtask

    task automatic predict_camera_step(input cam_item_t it, output cam_result_t r);
        longint cy, sy, cp, sp;
        longint f30[3], v[3], f[3], rt[3], u[3];
        if (it.cmd == CMD_LOAD)
        begin
            pred_pos[0] = longint'($signed(it.lx));
            pred_pos[1] = longint'($signed(it.ly));
            pred_pos[2] = longint'($signed(it.lz));
        end
        else
        begin
            angle_sincos(it.yaw, cy, sy);
            angle_sincos(it.pitch, cp, sp);
            f30[0] = round_shift(cy * cp, 30);
            f30[1] = sp;
            f30[2] = round_shift(sy * cp, 30);
            normalize_vec(f30, f);
            if (f[0] == 0 && f[2] == 0)
            begin
                rt = '{0, 0, 0};
                u = '{0, 0, 0};
            end
            else
            begin
                v[0] = f[2];
                v[1] = 0;
                v[2] = -f[0];
                normalize_vec(v, rt);
                v[0] = round_shift(f[1] * rt[2], 14);
                v[1] = round_shift(f[2] * rt[0] - f[0] * rt[2], 14);
                v[2] = round_shift(-f[1] * rt[0], 14);
                normalize_vec(v, u);
            end
            for (int i = 0; i < 3; i++)
            begin
                pred_basis[i] = f[i];
                pred_basis[3 + i] = rt[i];
                pred_basis[6 + i] = u[i];
                pred_pos[i] = clamp(pred_pos[i] + round_shift(f[i] * pred_speed, 6),
                                    -64'sd2147483648, 64'sd2147483647);
            end
        end
        r = '0;
        for (int i = 0; i < 9; i++)
            r[16 * i +: 16] = pred_basis[i][15:0];
        for (int i = 0; i < 3; i++)
            r[144 + 32 * i +: 32] = pred_pos[i][31:0];
    endtask

    // Driver: presents queued items, with random gaps between transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                void'(pending_items.pop_front());
            if (s_tvalid && !s_tready)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !hold_sender)
            begin
                if (!quiet_mode && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_items[0].lz, pending_items[0].ly,
                                pending_items[0].lx, pending_items[0].pitch,
                                pending_items[0].yaw};
                    s_tuser <= pending_items[0].cmd;
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // The prediction is computed at acceptance so the speed in force is used.
    always @(posedge clk)
    begin
        cam_result_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_camera_step({s_tuser[0], s_tdata[15:0], s_tdata[31:16],
                                 s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]}, r);
            expected_results.push_back(r);
        end
    end

    // Monitor: checks each output transaction and randomly stalls.
    always @(posedge clk)
    begin
        cam_result_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time,
                             m_tdata);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (e[16 * i +: 16] !== m_tdata[16 * i +: 16])
                        begin
                            $display("%0t basis field %0d: expected %h, actual %h",
                                     $time, i, e[16 * i +: 16], m_tdata[16 * i +: 16]);
                            error_count++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (e[144 + 32 * i +: 32] !== m_tdata[144 + 32 * i +: 32])
                        begin
                            $display("%0t position axis %0d: expected %h, actual %h",
                                     $time, i, e[144 + 32 * i +: 32],
                                     m_tdata[144 + 32 * i +: 32]);
                            error_count++;
                        end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 4) == 0)
            begin
                recv_gap <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic cam_item_t make_update(logic [15:0] yaw, logic [15:0] pitch);
        cam_item_t it;
        it.cmd = CMD_UPDATE;
        it.yaw = yaw;
        it.pitch = pitch;
        it.lx = $urandom;
        it.ly = $urandom;
        it.lz = $urandom;
        return it;
    endfunction

    function automatic cam_item_t make_load(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
        cam_item_t it;
        it.cmd = CMD_LOAD;
        it.yaw = 16'($urandom);
        it.pitch = 16'($urandom);
        it.lx = x;
        it.ly = y;
        it.lz = z;
        return it;
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 720)) * 128 - 46080);
            2: return 16'($signed($urandom_range(0, 2)) * 11520 - 11520);
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_speed(logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        pred_speed = longint'($signed(v));
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 6) == 0)
                case ($urandom_range(0, 2))
                    0: pending_items.push_back(make_load($urandom, $urandom, $urandom));
                    1: pending_items.push_back(make_load(32'h7FFF_0000, 32'h8000_0100,
                                                         $urandom));
                    default: pending_items.push_back(make_load(
                        $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0010,
                        $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0010,
                        $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0010));
                endcase
            else
                pending_items.push_back(make_update(random_angle(), random_angle()));
        end
    endtask

    initial
    begin
        pred_pos = '{0, 0, 0};
        pred_basis = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        pred_speed = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, both commands, vertical pitch, wrap-around.
        pending_items.push_back(make_load(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        pending_items.push_back(make_update(16'h0000, 16'h0000));
        wait_idle();
        write_speed(16'h7FFF);
        pending_items.push_back(make_update(16'h0000, 16'h2D00));
        pending_items.push_back(make_update(16'h1680, 16'hD300));
        pending_items.push_back(make_update(16'h7FFF, 16'h8000));
        pending_items.push_back(make_update(16'h8000, 16'h7FFF));
        pending_items.push_back(make_update(16'hA600, 16'h5A00));
        pending_items.push_back(make_update(16'h5A00, 16'hFFFF));
        pending_items.push_back(make_update(16'h2D00, 16'h1680));
        pending_items.push_back(make_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(make_update(16'h0000, 16'h0000));
        pending_items.push_back(make_update(16'h0000, 16'h2D00));
        pending_items.push_back(make_update(16'h2D00, 16'h1000));
        wait_idle();
        write_speed(16'h8000);
        pending_items.push_back(make_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(make_update(16'h0000, 16'hD300));
        pending_items.push_back(make_update(16'h5A00, 16'h1680));
        pending_items.push_back(make_update(16'hFFFF, 16'h0001));
        pending_items.push_back(make_load(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA));
        pending_items.push_back(make_update(16'h5555, 16'hAAAA));
        wait_idle();

        // Random phases at several step speeds.
        write_speed(16'h0100);
        random_phase(100);
        wait_idle();
        write_speed(16'($urandom));
        random_phase(100);
        // Let everything drain before sending more.
        while (pending_items.size() > 0 || s_tvalid)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        random_phase(60);
        wait_idle();
        write_speed(16'h0000);
        random_phase(60);
        wait_idle();
        write_speed(16'hFF00);
        quiet_mode = 1'b1;
        random_phase(60);
        wait_idle();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("FAIL");
        $finish;
    end
endmodule
